@@ src/cdt_pkg.sv @@
// shared types, register indexes and control bit positions for the countdown timer
package cdt_pkg;

    // default prescaler width and reset values
    localparam int PRESCALE_BITS_DEF = 10;
    localparam logic [31:0] PRESCALE_RESET = 32'h0000_007D;
    localparam logic [31:0] CONTROL_RESET  = 32'h003E_0000;

    // actions carried by a request beat
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // register word indexes
    localparam logic [3:0] REG_LOAD       = 4'd0;
    localparam logic [3:0] REG_VALUE      = 4'd1;
    localparam logic [3:0] REG_CONTROL    = 4'd2;
    localparam logic [3:0] REG_CLEAR      = 4'd3;
    localparam logic [3:0] REG_RAW_IRQ    = 4'd4;
    localparam logic [3:0] REG_MASKED_IRQ = 4'd5;
    localparam logic [3:0] REG_RELOAD     = 4'd6;
    localparam logic [3:0] REG_PRESCALE   = 4'd7;
    localparam logic [3:0] REG_FREE_COUNT = 4'd8;

    // control word bit positions
    localparam int CTL_32BIT_BIT  = 1;
    localparam int CTL_IRQ_EN_BIT = 5;
    localparam int CTL_ENABLE_BIT = 7;
    localparam int CTL_FREE_EN_BIT = 9;
    localparam int CTL_FDIV_LSB   = 16;
    localparam int CTL_FDIV_MSB   = 23;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
    } rsp_item_t;

endpackage

@@ src/countdown_timer_with_reload_core.sv @@
// top level of the countdown timer: request register, execute core, response register
//
// The request channel (req_valid, req_stall, req) carries one beat per clock
// tick, register write or register read. The response channel (rsp_valid,
// rsp_stall, rsp) returns exactly one beat per request: read data (zero for
// ticks and writes) and the masked interrupt line after that request.
// A beat is taken on a rising edge with valid high and stall low.
// An accepted beat sits in the request register while the execute logic
// works on it, and the result lands in the response register when the
// response side is free. Throughput is one request per cycle while the
// receiver does not stall; the state update is a single combinational
// pass, so each beat sees the state the previous one left.
// When the receiver stalls, the response register holds its beat and the
// request register keeps its beat too; req_stall rises only once both are
// full, so if the request register was empty one more request is still
// taken after the response side stops.
// Reset clears both valid flags and puts the timer in its reset state:
// counters zero, control 0x003E0000, prescale 0x7D, overflow clear.
module countdown_timer_with_reload_core #(
    parameter int PRESCALE_BITS = cdt_pkg::PRESCALE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cdt_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cdt_pkg::rsp_item_t rsp
);
    import cdt_pkg::*;

    logic      req_valid_reg;
    req_item_t req_item_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    rsp_item_t exec_result;
    logic      advance;
    logic      rsp_free;

    // pipeline handshake
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = req_valid_reg && rsp_free;
    assign req_stall = req_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    // execute core
    cdt_core #(
        .PRESCALE_BITS(PRESCALE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (advance),
        .item   (req_item_reg),
        .result (exec_result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                req_valid_reg <= req_valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_item_reg <= req;
        end
        if (advance)
        begin
            rsp_item_reg <= exec_result;
        end
    end

endmodule

@@ src/cdt_core.sv @@
// timer state registers and the single-pass execute logic for one beat
module cdt_core #(
    parameter int PRESCALE_BITS = cdt_pkg::PRESCALE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec,
    input  cdt_pkg::req_item_t item,
    output cdt_pkg::rsp_item_t result
);
    import cdt_pkg::*;

    logic [31:0]              load_reg, load_next;
    logic [31:0]              count_reg, count_next;
    logic [31:0]              control_reg, control_next;
    logic [31:0]              reload_reg, reload_next;
    logic [PRESCALE_BITS-1:0] prescale_reg, prescale_next;
    logic [PRESCALE_BITS-1:0] pcount_reg, pcount_next;
    logic                     overflow_reg, overflow_next;
    logic [31:0]              free_reg, free_next;
    logic [7:0]               fpcount_reg, fpcount_next;

    logic [31:0] count_cur;
    logic [31:0] reload_cur;
    logic [31:0] read_word;
    logic        wide_mode;

    // counter view in the selected width
    assign wide_mode  = control_reg[CTL_32BIT_BIT];
    assign count_cur  = wide_mode ? count_reg  : {16'd0, count_reg[15:0]};
    assign reload_cur = wide_mode ? reload_reg : {16'd0, reload_reg[15:0]};

    // next state for tick and write beats
    always_comb
    begin
        load_next     = load_reg;
        count_next    = count_reg;
        control_next  = control_reg;
        reload_next   = reload_reg;
        prescale_next = prescale_reg;
        pcount_next   = pcount_reg;
        overflow_next = overflow_reg;
        free_next     = free_reg;
        fpcount_next  = fpcount_reg;
        case (item.action)
            ACT_TICK:
            begin
                if (control_reg[CTL_ENABLE_BIT])
                begin
                    if (pcount_reg >= prescale_reg)
                    begin
                        pcount_next = '0;
                        if (count_cur == 32'd0)
                        begin
                            overflow_next = 1'b1;
                            count_next    = reload_cur;
                        end
                        else
                        begin
                            count_next = count_cur - 32'd1;
                        end
                    end
                    else
                    begin
                        pcount_next = pcount_reg + PRESCALE_BITS'(1);
                    end
                end
                if (control_reg[CTL_FREE_EN_BIT])
                begin
                    if (fpcount_reg >= control_reg[CTL_FDIV_MSB:CTL_FDIV_LSB])
                    begin
                        fpcount_next = 8'd0;
                        free_next    = free_reg + 32'd1;
                    end
                    else
                    begin
                        fpcount_next = fpcount_reg + 8'd1;
                    end
                end
            end
            ACT_WRITE:
            begin
                case (item.reg_index)
                    REG_LOAD:
                    begin
                        load_next  = item.write_data;
                        count_next = item.write_data;
                    end
                    REG_CONTROL:  control_next  = item.write_data;
                    REG_CLEAR:    overflow_next = 1'b0;
                    REG_RELOAD:   reload_next   = item.write_data;
                    REG_PRESCALE: prescale_next = item.write_data[PRESCALE_BITS-1:0];
                    default:      ;
                endcase
            end
            default: ;
        endcase
    end

    // read mux over the current state
    always_comb
    begin
        read_word = 32'd0;
        if (item.action == ACT_READ)
        begin
            case (item.reg_index)
                REG_LOAD:       read_word = load_reg;
                REG_VALUE:      read_word = count_reg;
                REG_CONTROL:    read_word = control_reg;
                REG_RAW_IRQ:    read_word = {31'd0, overflow_reg};
                REG_MASKED_IRQ: read_word = {31'd0, overflow_reg & control_reg[CTL_IRQ_EN_BIT]};
                REG_RELOAD:     read_word = reload_reg;
                REG_PRESCALE:   read_word = {{(32-PRESCALE_BITS){1'b0}}, prescale_reg};
                REG_FREE_COUNT: read_word = free_reg;
                default:        read_word = 32'd0;
            endcase
        end
    end

    // result reflects the interrupt after this beat
    assign result.read_data = read_word;
    assign result.irq_line  = overflow_next & control_next[CTL_IRQ_EN_BIT];

    // state registers, updated once per executed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg     <= 32'd0;
            count_reg    <= 32'd0;
            control_reg  <= CONTROL_RESET;
            reload_reg   <= 32'd0;
            prescale_reg <= PRESCALE_RESET[PRESCALE_BITS-1:0];
            pcount_reg   <= '0;
            overflow_reg <= 1'b0;
            free_reg     <= 32'd0;
            fpcount_reg  <= 8'd0;
        end
        else if (exec)
        begin
            load_reg     <= load_next;
            count_reg    <= count_next;
            control_reg  <= control_next;
            reload_reg   <= reload_next;
            prescale_reg <= prescale_next;
            pcount_reg   <= pcount_next;
            overflow_reg <= overflow_next;
            free_reg     <= free_next;
            fpcount_reg  <= fpcount_next;
        end
    end

endmodule
